FILE: src/preg_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the picture register interface
// no dependencies; used by preg_vram, preg_regs and picture_register_interface

package preg_pkg;

  localparam int NAMETABLE_BYTES_DEF = 2048;
  localparam int OAM_BYTES           = 256;
  localparam int OAM_AW              = 8;
  localparam int PAL_BYTES           = 32;
  localparam int PAL_AW              = 5;

  // transaction kinds
  localparam logic [2:0] ACT_READ      = 3'd0;
  localparam logic [2:0] ACT_WRITE     = 3'd1;
  localparam logic [2:0] ACT_VBLANK    = 3'd2;
  localparam logic [2:0] ACT_PRERENDER = 3'd3;
  localparam logic [2:0] ACT_DMA       = 3'd4;

  // register numbers
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_PTR  = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // status bit positions
  localparam int STAT_VBLANK = 2;
  localparam int STAT_SPR0   = 1;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] dma_index;
    logic [7:0] ext_read_data;
    logic       sprite_zero_event;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        nmi_request;
    logic        ext_write_valid;
    logic [12:0] ext_addr;
    logic [7:0]  ext_write_data;
    logic [14:0] current_scroll_v;
    logic [2:0]  current_fine_x;
  } result_t;

  typedef struct packed {
    logic [13:0] vaddr;
    logic [7:0]  oam_sel;
    logic        mirror;
  } vram_rd_req_t;

  typedef struct packed {
    logic       oam_we;
    logic [7:0] oam_sel;
    logic       nt_we;
    logic       pal_we;
    logic [7:0] wdata;
  } vram_wr_req_t;

  typedef struct packed {
    logic [7:0] oam;
    logic [7:0] nt;
    logic [7:0] pal;
  } vram_rd_t;

endpackage

FILE: src/preg_in_if.sv
`timescale 1ns / 1ps
// input channel: valid/ready handshake with one register or event transaction
// no dependencies

interface preg_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [2:0] reg_index;
  logic [7:0] write_data;
  logic [7:0] dma_index;
  logic [7:0] ext_read_data;
  logic       sprite_zero_event;

  modport source (
    output valid, action, reg_index, write_data, dma_index, ext_read_data,
           sprite_zero_event,
    input  ready
  );
  modport sink (
    input  valid, action, reg_index, write_data, dma_index, ext_read_data,
           sprite_zero_event,
    output ready
  );
endinterface

FILE: src/preg_out_if.sv
`timescale 1ns / 1ps
// result channel: valid/ready handshake with one result transaction
// no dependencies

interface preg_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        nmi_request;
  logic        ext_write_valid;
  logic [12:0] ext_addr;
  logic [7:0]  ext_write_data;
  logic [14:0] current_scroll_v;
  logic [2:0]  current_fine_x;

  modport source (
    output valid, read_data, nmi_request, ext_write_valid, ext_addr,
           ext_write_data, current_scroll_v, current_fine_x,
    input  ready
  );
  modport sink (
    input  valid, read_data, nmi_request, ext_write_valid, ext_addr,
           ext_write_data, current_scroll_v, current_fine_x,
    output ready
  );
endinterface

FILE: src/preg_vram.sv
`timescale 1ns / 1ps
// oam, nametable and palette memories with registered reads and a clearing sweep
// depends on preg_pkg

module preg_vram #(
  parameter int NAMETABLE_BYTES = preg_pkg::NAMETABLE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  preg_pkg::vram_rd_req_t rd_req,
  input  preg_pkg::vram_wr_req_t wr_req,
  output preg_pkg::vram_rd_t     rd_data,
  output logic                  clr_busy
);

  localparam int NtAw = $clog2(NAMETABLE_BYTES);

  logic [7:0] nt_mem  [NAMETABLE_BYTES];
  logic [7:0] oam_mem [preg_pkg::OAM_BYTES];
  logic [7:0] pal_mem [preg_pkg::PAL_BYTES];

  logic [NtAw-1:0]             clr_cnt_r;
  logic                        clr_busy_r;
  logic [NtAw-1:0]             nt_addr;
  logic [preg_pkg::PAL_AW-1:0] pal_addr;
  logic [7:0]                  nt_q_r, oam_q_r, pal_q_r;

  // page select from mirroring, same entry for v and for v minus 0x1000
  always_comb begin
    nt_addr  = NtAw'({(rd_req.mirror ? rd_req.vaddr[10] : rd_req.vaddr[11]),
                      rd_req.vaddr[9:0]});
    // entries 0x10/0x14/0x18/0x1c alias the low four
    pal_addr = {rd_req.vaddr[4] & (rd_req.vaddr[1:0] != 2'b00), rd_req.vaddr[3:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == NtAw'(NAMETABLE_BYTES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      nt_mem[clr_cnt_r]                        <= 8'h00;
      oam_mem[clr_cnt_r[preg_pkg::OAM_AW-1:0]] <= 8'h00;
      pal_mem[clr_cnt_r[preg_pkg::PAL_AW-1:0]] <= 8'h00;
    end else begin
      if (wr_req.nt_we) begin
        nt_mem[nt_addr] <= wr_req.wdata;
      end
      if (wr_req.oam_we) begin
        oam_mem[wr_req.oam_sel] <= wr_req.wdata;
      end
      if (wr_req.pal_we) begin
        pal_mem[pal_addr] <= wr_req.wdata;
      end
    end
    nt_q_r  <= nt_mem[nt_addr];
    oam_q_r <= oam_mem[rd_req.oam_sel];
    pal_q_r <= pal_mem[pal_addr];
  end

  assign rd_data.nt  = nt_q_r;
  assign rd_data.oam = oam_q_r;
  assign rd_data.pal = pal_q_r;
  assign clr_busy    = clr_busy_r;

endmodule

FILE: src/preg_regs.sv
`timescale 1ns / 1ps
// scroll, control and status registers with the per-transaction update and result
// depends on preg_pkg; drives the memory requests of preg_vram

module preg_regs (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  input  logic                   commit,
  input  preg_pkg::item_t        item,
  input  preg_pkg::vram_rd_t     rd_data,
  output preg_pkg::vram_rd_req_t rd_req,
  output preg_pkg::vram_wr_req_t wr_req,
  output preg_pkg::result_t      result
);

  logic [14:0] v_r, v_nxt, t_r, t_nxt, v_inc;
  logic [2:0]  x_r, x_nxt, status_r, status_nxt;
  logic        toggle_r, toggle_nxt, mirror_r;
  logic [7:0]  buf_r, buf_nxt, ctrl_r, ctrl_nxt, oam_ptr_r, oam_ptr_nxt;
  logic [7:0]  val;
  logic        is_ext, is_pal;
  preg_pkg::vram_wr_req_t wr_c;
  preg_pkg::result_t      res;

  assign val    = item.write_data;
  assign is_ext = ~v_r[13];
  assign is_pal = (v_r[13:8] == 6'h3F);
  assign v_inc  = v_r + (ctrl_r[2] ? 15'd32 : 15'd1);

  always_comb begin
    v_nxt       = v_r;
    t_nxt       = t_r;
    x_nxt       = x_r;
    toggle_nxt  = toggle_r;
    buf_nxt     = buf_r;
    ctrl_nxt    = ctrl_r;
    status_nxt  = status_r;
    oam_ptr_nxt = oam_ptr_r;
    res         = '0;
    wr_c        = '0;
    wr_c.wdata  = val;
    case (item.action)
      preg_pkg::ACT_READ: begin
        case (item.reg_index)
          preg_pkg::REG_STATUS: begin
            res.read_data                  = {status_r, buf_r[4:0]};
            status_nxt[preg_pkg::STAT_VBLANK] = 1'b0;
            toggle_nxt                     = 1'b0;
          end
          preg_pkg::REG_OAM_DATA: begin
            res.read_data = rd_data.oam;
          end
          preg_pkg::REG_DATA: begin
            if (!is_pal) begin
              res.read_data = buf_r;
              if (is_ext) begin
                buf_nxt      = item.ext_read_data;
                res.ext_addr = v_r[12:0];
              end else begin
                buf_nxt = rd_data.nt;
              end
            end else begin
              res.read_data = rd_data.pal;
              buf_nxt       = rd_data.nt;
            end
            v_nxt = v_inc;
          end
          default: ;
        endcase
      end
      preg_pkg::ACT_WRITE: begin
        case (item.reg_index)
          preg_pkg::REG_CTRL: begin
            res.nmi_request = ~ctrl_r[7] & val[7] & status_r[preg_pkg::STAT_VBLANK];
            ctrl_nxt        = val;
            t_nxt           = {t_r[14:12], val[1:0], t_r[9:0]};
          end
          preg_pkg::REG_OAM_PTR: begin
            oam_ptr_nxt = val;
          end
          preg_pkg::REG_OAM_DATA: begin
            wr_c.oam_we  = 1'b1;
            wr_c.oam_sel = oam_ptr_r;
            oam_ptr_nxt  = oam_ptr_r + 8'd1;
          end
          preg_pkg::REG_SCROLL: begin
            if (!toggle_r) begin
              t_nxt      = {t_r[14:5], val[7:3]};
              x_nxt      = val[2:0];
              toggle_nxt = 1'b1;
            end else begin
              t_nxt      = {val[2:0], t_r[11:10], val[7:3], t_r[4:0]};
              toggle_nxt = 1'b0;
            end
          end
          preg_pkg::REG_ADDR: begin
            if (!toggle_r) begin
              t_nxt      = {1'b0, val[5:0], t_r[7:0]};
              toggle_nxt = 1'b1;
            end else begin
              t_nxt      = {t_r[14:8], val};
              v_nxt      = {t_r[14:8], val};
              toggle_nxt = 1'b0;
            end
          end
          preg_pkg::REG_DATA: begin
            if (is_ext) begin
              res.ext_write_valid = 1'b1;
              res.ext_addr        = v_r[12:0];
              res.ext_write_data  = val;
            end else if (!is_pal) begin
              wr_c.nt_we = 1'b1;
            end else begin
              wr_c.pal_we = 1'b1;
            end
            v_nxt = v_inc;
          end
          default: ;
        endcase
      end
      preg_pkg::ACT_VBLANK: begin
        status_nxt[preg_pkg::STAT_VBLANK] = 1'b1;
        if (item.sprite_zero_event) begin
          status_nxt[preg_pkg::STAT_SPR0] = 1'b1;
        end
        res.nmi_request = ctrl_r[7];
      end
      preg_pkg::ACT_PRERENDER: begin
        status_nxt = 3'b000;
      end
      preg_pkg::ACT_DMA: begin
        wr_c.oam_we  = 1'b1;
        wr_c.oam_sel = item.dma_index;
      end
      default: ;
    endcase
    res.current_scroll_v = v_nxt;
    res.current_fine_x   = x_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      t_r       <= '0;
      x_r       <= '0;
      toggle_r  <= 1'b0;
      buf_r     <= '0;
      ctrl_r    <= '0;
      status_r  <= '0;
      oam_ptr_r <= '0;
      mirror_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        mirror_r <= cfg_wdata;
      end
      if (commit) begin
        v_r       <= v_nxt;
        t_r       <= t_nxt;
        x_r       <= x_nxt;
        toggle_r  <= toggle_nxt;
        buf_r     <= buf_nxt;
        ctrl_r    <= ctrl_nxt;
        status_r  <= status_nxt;
        oam_ptr_r <= oam_ptr_nxt;
      end
    end
  end

  assign rd_req.vaddr   = v_r[13:0];
  assign rd_req.oam_sel = oam_ptr_r;
  assign rd_req.mirror  = mirror_r;
  assign wr_req         = commit ? wr_c : '0;
  assign result         = res;

endmodule

FILE: src/picture_register_interface.sv
`timescale 1ns / 1ps
// picture register interface: one transaction at a time; its result is registered in ST_EXEC,
// which holds while the result register is full and uses the accept-cycle memory read
// after rst_n the nametable, oam and palette are swept to zero with in_ch.ready low, one
// entry per cycle over NAMETABLE_BYTES entries; configuration writes are taken throughout
// depends on preg_pkg, preg_in_if, preg_out_if, preg_vram and preg_regs

module picture_register_interface #(
  parameter int NAMETABLE_BYTES = preg_pkg::NAMETABLE_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  preg_in_if.sink         in_ch,
  preg_out_if.source      out_ch,
  input  logic            cfg_we,
  input  logic            cfg_wdata
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                 state_r;
  logic                   out_valid_r;
  preg_pkg::result_t      out_r;
  preg_pkg::item_t        item_r;
  preg_pkg::item_t        item_in;
  preg_pkg::result_t      result;
  preg_pkg::vram_rd_req_t rd_req;
  preg_pkg::vram_wr_req_t wr_req;
  preg_pkg::vram_rd_t     rd_data;
  logic                   clr_busy;
  logic                   accept;
  logic                   out_free;
  logic                   commit;

  // gather the incoming transaction
  assign item_in.action            = in_ch.action;
  assign item_in.reg_index         = in_ch.reg_index;
  assign item_in.write_data        = in_ch.write_data;
  assign item_in.dma_index         = in_ch.dma_index;
  assign item_in.ext_read_data     = in_ch.ext_read_data;
  assign item_in.sprite_zero_event = in_ch.sprite_zero_event;

  // take a transaction only when idle and the memories are cleared;
  // memory reads at the current state run during this cycle
  assign in_ch.ready = (state_r == ST_IDLE) && !clr_busy;
  assign accept      = in_ch.valid && in_ch.ready;

  // result register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ch.ready;
  // in ST_EXEC the read data is in; state and memories update together once the result register is free
  assign commit   = (state_r == ST_EXEC) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (out_valid_r && out_ch.ready) begin
            out_valid_r <= 1'b0;
          end
          if (accept) begin
            item_r  <= item_in;
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            out_r       <= result;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  preg_vram #(
    .NAMETABLE_BYTES(NAMETABLE_BYTES)
  ) u_vram (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_req   (rd_req),
    .wr_req   (wr_req),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  preg_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .commit    (commit),
    .item      (item_r),
    .rd_data   (rd_data),
    .rd_req    (rd_req),
    .wr_req    (wr_req),
    .result    (result)
  );

  assign out_ch.valid            = out_valid_r;
  assign out_ch.read_data        = out_r.read_data;
  assign out_ch.nmi_request      = out_r.nmi_request;
  assign out_ch.ext_write_valid  = out_r.ext_write_valid;
  assign out_ch.ext_addr         = out_r.ext_addr;
  assign out_ch.ext_write_data   = out_r.ext_write_data;
  assign out_ch.current_scroll_v = out_r.current_scroll_v;
  assign out_ch.current_fine_x   = out_r.current_fine_x;

  // no transaction is taken while the clearing sweep runs
  a_no_accept_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ch.ready)
    else $error("transaction accepted during memory clear");

  // an accepted transaction moves to execute and blocks the next one
  a_accept_to_exec : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC) && !in_ch.ready)
    else $error("accept did not enter execute");

  // a new result appears only after an execute cycle
  a_result_from_exec : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EXEC)
    else $error("result without execute");

  // a pattern write never carries read data or an nmi
  a_ext_write_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ext_write_valid) |->
      (out_ch.read_data == 8'h00) && !out_ch.nmi_request)
    else $error("pattern write mixed with read result");

endmodule
